// ----- design/hsct_pkg.sv -----
// Package for the hard-sphere collision-time block.
// Holds payload structs, field widths and default constants; no dependencies.
package hsct_pkg;

  localparam int DEF_MAX_PARTICLES = 1024;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int IDX_W  = 10;
  localparam int PART_W = 11;
  localparam int CFG_W  = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_COLL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_TOL = 3'd4;

  localparam logic [30:0] RST_BOX     = 31'd655360;
  localparam logic [30:0] RST_NO_COLL = 31'h7FFFFFFF;
  localparam logic [15:0] RST_NEG_TOL = 16'd16;

  typedef struct packed {
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic signed [31:0] rel_pos_x;
    logic signed [31:0] rel_pos_y;
    logic signed [31:0] rel_pos_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic [30:0]       contact_distance;
    logic              first_pair;
    logic              last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_time;
    logic [PART_W-1:0]  first_partner;
    logic signed [31:0] second_time;
    logic [PART_W-1:0]  second_partner;
    logic               second_lowered;
    logic               done_res;
    logic               negative_error;
  } out_item_t;

endpackage

// ----- design/hsct_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module hsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- design/hsct_core.sv -----
// Contact-time datapath: minimum image, dot products, root and quotient.
// Uses hsct_pkg; one shared 32x32 multiplier with serial remainder, root and quotient steps.
module hsct_core
  import hsct_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  in_item_t    item,
  input  logic [30:0] box_x,
  input  logic [30:0] box_y,
  input  logic [30:0] box_z,
  output logic        done,
  output logic        hit,
  output logic signed [31:0] t_out
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WLOAD = 4'd1;
  localparam logic [3:0] S_WRAP  = 4'd2;
  localparam logic [3:0] S_WFIX  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SS    = 4'd5;
  localparam logic [3:0] S_DISC  = 4'd6;
  localparam logic [3:0] S_WIDE  = 4'd7;
  localparam logic [3:0] S_GAP   = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_NUM   = 4'd11;
  localparam logic [3:0] S_DCHK  = 4'd12;
  localparam logic [3:0] S_DIV   = 4'd13;
  localparam logic [3:0] S_SAT   = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state;
  logic [6:0] cnt;
  logic [1:0] ax, ph, wsel;
  logic signed [32:0] r [3];
  logic signed [32:0] v [3];
  logic [30:0] s;
  logic [31:0] wabs;
  logic [30:0] wrem;
  logic wneg;
  logic [63:0] pos, neg, r2, v2, ss, bm, root;
  logic [127:0] acc, P, B, Q, d;
  logic [64:0] srem;
  logic [127:0] num;
  logic [63:0] drem;
  logic [31:0] quo;
  logic nneg, big;

  logic [30:0] len;
  logic signed [32:0] cur_r, cur_v;
  logic [31:0] mag_r, mag_v;
  logic [31:0] wtr;
  logic [30:0] wmod;
  logic [63:0] wa, wb;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [6:0] shamt;
  logic [127:0] prod_sh;
  logic [66:0] trem, trial, sdiff;
  logic [127:0] gap;
  logic [63:0] nm;
  logic [64:0] dtr;

  always_comb begin
    len = (ax == 2'd0) ? box_x : (ax == 2'd1) ? box_y : box_z;
    cur_r = r[ax];
    cur_v = v[ax];
    mag_r = cur_r[32] ? 32'(-cur_r) : 32'(cur_r);
    mag_v = cur_v[32] ? 32'(-cur_v) : 32'(cur_v);
    wtr = {wrem, wabs[31]};
    wmod = (wneg && wrem != 31'd0) ? len - wrem : wrem;

    wa = v2;
    wb = r2;
    if (wsel == 2'd1) begin
      wa = bm;
      wb = bm;
    end else if (wsel == 2'd2) begin
      wb = ss;
    end

    ma = mag_r;
    mb = mag_v;
    if (state == S_MUL) begin
      if (ph == 2'd1) begin
        mb = mag_r;
      end else if (ph == 2'd2) begin
        ma = mag_v;
      end
    end else if (state == S_SS) begin
      ma = {1'b0, s};
      mb = {1'b0, s};
    end else begin
      ma = cnt[0] ? wa[63:32] : wa[31:0];
      mb = cnt[1] ? wb[63:32] : wb[31:0];
    end
    prod = 64'(ma) * 64'(mb);
    shamt = 7'({cnt[1], 5'd0}) + 7'({cnt[0], 5'd0});
    prod_sh = {64'd0, prod} << shamt;

    trem = {srem, d[127:126]};
    trial = {1'b0, root, 2'b01};
    sdiff = trem - trial;
    gap = (P >= B) ? P - B : 128'd0;
    nm = (root > bm) ? root - bm : bm - root;
    dtr = {drem, num[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r[0] <= 33'(item.rel_pos_x);
            r[1] <= 33'(item.rel_pos_y);
            r[2] <= 33'(item.rel_pos_z);
            v[0] <= 33'(item.rel_vel_x);
            v[1] <= 33'(item.rel_vel_y);
            v[2] <= 33'(item.rel_vel_z);
            s <= item.contact_distance;
            ax <= 2'd0;
            hit <= 1'b0;
            state <= S_WLOAD;
          end
        end
        S_WLOAD: begin
          wabs <= mag_r;
          wneg <= cur_r[32];
          wrem <= '0;
          cnt <= 7'd31;
          if (len == 31'd0) begin
            if (ax == 2'd2) begin
              ax <= 2'd0; ph <= 2'd0;
              pos <= '0; neg <= '0; r2 <= '0; v2 <= '0;
              state <= S_MUL;
            end else begin
              ax <= ax + 2'd1;
            end
          end else begin
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          wabs <= {wabs[30:0], 1'b0};
          if (wtr >= {1'b0, len}) begin
            wrem <= wtr[30:0] - len;
          end else begin
            wrem <= wtr[30:0];
          end
          if (cnt == 7'd0) begin
            state <= S_WFIX;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end
        S_WFIX: begin
          if ({wmod, 1'b0} > {1'b0, len}) begin
            r[ax] <= $signed({2'b00, wmod}) - $signed({2'b00, len});
          end else begin
            r[ax] <= $signed({2'b00, wmod});
          end
          if (ax == 2'd2) begin
            ax <= 2'd0; ph <= 2'd0;
            pos <= '0; neg <= '0; r2 <= '0; v2 <= '0;
            state <= S_MUL;
          end else begin
            ax <= ax + 2'd1;
            state <= S_WLOAD;
          end
        end
        S_MUL: begin
          case (ph)
            2'd0: begin
              if (cur_r[32] != cur_v[32]) neg <= neg + prod;
              else pos <= pos + prod;
            end
            2'd1: r2 <= r2 + prod;
            default: v2 <= v2 + prod;
          endcase
          if (ph == 2'd2) begin
            ph <= 2'd0;
            if (ax == 2'd2) begin
              state <= S_SS;
            end else begin
              ax <= ax + 2'd1;
            end
          end else begin
            ph <= ph + 2'd1;
          end
        end
        S_SS: begin
          ss <= prod;
          state <= S_DISC;
        end
        S_DISC: begin
          if (neg <= pos || v2 == 64'd0) begin
            state <= S_DONE;
          end else begin
            bm <= neg - pos;
            wsel <= 2'd0;
            cnt <= 7'd0;
            acc <= '0;
            state <= S_WIDE;
          end
        end
        S_WIDE: begin
          if (cnt[1:0] == 2'd3) begin
            case (wsel)
              2'd0: P <= acc + prod_sh;
              2'd1: B <= acc + prod_sh;
              default: Q <= acc + prod_sh;
            endcase
            acc <= '0;
            cnt <= 7'd0;
            if (wsel == 2'd2) begin
              state <= S_GAP;
            end else begin
              wsel <= wsel + 2'd1;
            end
          end else begin
            acc <= acc + prod_sh;
            cnt <= cnt + 7'd1;
          end
        end
        S_GAP: begin
          P <= gap;
          state <= S_CMP;
        end
        S_CMP: begin
          if (Q <= P) begin
            state <= S_DONE;
          end else begin
            d <= Q - P;
            srem <= '0;
            root <= '0;
            cnt <= 7'd63;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          d <= {d[125:0], 2'b00};
          if (trem >= trial) begin
            srem <= sdiff[64:0];
            root <= {root[62:0], 1'b1};
          end else begin
            srem <= trem[64:0];
            root <= {root[62:0], 1'b0};
          end
          if (cnt == 7'd0) begin
            state <= S_NUM;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end
        S_NUM: begin
          nneg <= root > bm;
          num <= 128'(nm) << FRAC_BITS;
          state <= S_DCHK;
        end
        S_DCHK: begin
          quo <= '0;
          if (num[127:32] >= {32'd0, v2}) begin
            big <= 1'b1;
            state <= S_SAT;
          end else begin
            big <= 1'b0;
            drem <= num[95:32];
            cnt <= 7'd31;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          num[31:0] <= {num[30:0], 1'b0};
          if (dtr >= {1'b0, v2}) begin
            drem <= dtr[63:0] - v2;
            quo <= {quo[30:0], 1'b1};
          end else begin
            drem <= dtr[63:0];
            quo <= {quo[30:0], 1'b0};
          end
          if (cnt == 7'd0) begin
            state <= S_SAT;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end
        S_SAT: begin
          hit <= 1'b1;
          if (big) begin
            t_out <= nneg ? 32'sh80000000 : 32'sh7FFFFFFF;
          end else if (nneg) begin
            t_out <= quo[31] ? 32'sh80000000 : -$signed(quo);
          end else begin
            t_out <= quo[31] ? 32'sh7FFFFFFF : $signed(quo);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/hard_sphere_collision_time.sv -----
// Hard-sphere collision-time block: one candidate pair per transaction.
// The minimum image, dot products, wide products, root, quotient and table steps run in turn;
// pairs that do not approach skip the wide products, root and quotient, and a zero box length
// skips the minimum image on its axis.
// in_ready is low until the result is taken, so one transaction is in flight at a time.
// Synchronous active-high reset restores defaults and clears every table entry before in_ready rises.
module hard_sphere_collision_time
  import hsct_pkg::*;
#(
  parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
  parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam int AW = $clog2(MAX_PARTICLES);
  localparam logic [3:0] T_CLR = 4'd0, T_IDLE = 4'd1, T_CALC = 4'd2, T_RDI = 4'd3,
    T_RDI2 = 4'd4, T_WRI = 4'd5, T_RDJ = 4'd6, T_RDJ2 = 4'd7, T_WRJ = 4'd8,
    T_RDA = 4'd9, T_RDA2 = 4'd10, T_OUT = 4'd11;

  logic [30:0] box_x, box_y, box_z, no_coll;
  logic [15:0] neg_tol;
  logic [3:0] state;
  logic [AW:0] clr;
  in_item_t it;
  logic iok, jok, cdone, chit, lowered;
  logic signed [31:0] t;
  logic we;
  logic [AW-1:0] addr;
  logic [42:0] wdata, rdata;
  logic signed [31:0] ti;
  logic [10:0] pi;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= RST_BOX; box_y <= RST_BOX; box_z <= RST_BOX;
      no_coll <= RST_NO_COLL; neg_tol <= RST_NEG_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X: box_x <= cfg_data;
        REG_BOX_Y: box_y <= cfg_data;
        REG_BOX_Z: box_z <= cfg_data;
        REG_NO_COLL: no_coll <= cfg_data;
        REG_NEG_TOL: neg_tol <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hsct_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk, .rst, .start(in_valid && in_ready), .item(in_data),
    .box_x, .box_y, .box_z, .done(cdone), .hit(chit), .t_out(t));

  hsct_ram #(.WIDTH(43), .DEPTH(MAX_PARTICLES)) u_ram (
    .clk, .we, .addr, .wdata, .rdata);

  assign in_ready = (state == T_IDLE);
  assign iok = 32'(it.first_index) < MAX_PARTICLES;
  assign jok = 32'(it.second_index) < MAX_PARTICLES;

  logic signed [31:0] curt;
  logic [10:0] curp;
  always_comb begin
    curt = $signed(rdata[42:11]);
    curp = rdata[10:0];
    we = 1'b0;
    addr = AW'(it.first_index);
    wdata = {32'(no_coll), 11'(MAX_PARTICLES)};
    unique case (state) inside
      T_CLR: begin
        we = 1'b1;
        addr = clr[AW-1:0];
        wdata = {32'(RST_NO_COLL), 11'(MAX_PARTICLES)};
      end
      T_WRI: begin
        we = iok;
        if (it.first_pair) begin
          curt = $signed(32'(no_coll)); curp = 11'(MAX_PARTICLES);
        end
        wdata = {curt, curp};
        if (chit && it.first_index != it.second_index && t < curt)
          wdata = {t, 11'(it.second_index)};
      end
      T_RDJ, T_RDJ2: addr = AW'(it.second_index);
      T_WRJ: begin
        addr = AW'(it.second_index);
        we = jok && lowered;
        wdata = {t, 11'(it.first_index)};
      end
      T_RDA, T_RDA2: addr = AW'(it.first_index);
      default: ;
    endcase
  end

  assign ti = iok ? curt : $signed(32'(no_coll));
  assign pi = iok ? curp : 11'(MAX_PARTICLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_CLR; clr <= '0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        T_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(MAX_PARTICLES - 1)) state <= T_IDLE;
        end
        T_IDLE: if (in_valid) begin it <= in_data; state <= T_CALC; end
        T_CALC: if (cdone) state <= T_RDI;
        T_RDI: state <= T_RDI2;
        T_RDI2: state <= T_WRI;
        T_WRI: state <= T_RDJ;
        T_RDJ: state <= T_RDJ2;
        T_RDJ2: begin
          lowered <= jok && chit && it.first_index != it.second_index && t < curt;
          state <= T_WRJ;
        end
        T_WRJ: state <= T_RDA;
        T_RDA: state <= T_RDA2;
        T_RDA2: begin
          out_data.first_time <= ti;
          out_data.first_partner <= pi;
          out_data.second_lowered <= lowered;
          out_data.done_res <= it.last_pair;
          out_data.negative_error <= it.last_pair &&
            (33'(ti) < -$signed({17'd0, neg_tol}));
          if (!jok) begin
            out_data.second_time <= $signed(32'(no_coll));
            out_data.second_partner <= 11'(MAX_PARTICLES);
          end else if (lowered) begin
            out_data.second_time <= t;
            out_data.second_partner <= 11'(it.first_index);
          end else if (it.first_index == it.second_index) begin
            out_data.second_time <= ti;
            out_data.second_partner <= pi;
          end
          out_valid <= 1'b1;
          state <= T_OUT;
        end
        T_OUT: if (out_ready) begin out_valid <= 1'b0; state <= T_IDLE; end
        default: state <= T_IDLE;
      endcase
      if (state == T_RDJ2 && jok) begin
        out_data.second_time <= curt;
        out_data.second_partner <= curp;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == T_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("accepting while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == T_WRJ && we) |-> $past(lowered) || lowered)
    else $error("j written without lowering");
endmodule
